// ===== rtl/hpq_pkg.sv =====
// Shared types and codes for the min-heap priority queue.
`timescale 1ns / 1ps

package hpq_pkg;

  localparam int KEY_BITS    = 24;
  localparam int COORD_BITS  = 12;
  localparam int HANDLE_BITS = 16;
  localparam int MODE_BITS   = 2;
  localparam int STATUS_BITS = 2;
  localparam int CNT_BITS    = 9;

  // Operation codes carried in the mode field.
  localparam logic [MODE_BITS-1:0] MODE_INSERT  = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_EXTRACT = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FIND    = 2'd2;
  localparam logic [MODE_BITS-1:0] MODE_CLEAR   = 2'd3;

  // Result status codes.
  localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_FULL  = 2'd2;

  // One stored heap entry.
  typedef struct packed {
    logic [KEY_BITS-1:0]    cost;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [HANDLE_BITS-1:0] handle;
  } entry_t;

  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [KEY_BITS-1:0]    cost_key;
    logic [COORD_BITS-1:0]  coord_x;
    logic [COORD_BITS-1:0]  coord_y;
    logic [HANDLE_BITS-1:0] node_handle;
  } in_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [KEY_BITS-1:0]    out_cost;
    logic [COORD_BITS-1:0]  out_x;
    logic [COORD_BITS-1:0]  out_y;
    logic [HANDLE_BITS-1:0] out_handle;
    logic [CNT_BITS-1:0]    entry_count;
    logic                   is_empty;
  } out_t;

endpackage

// ===== rtl/hpq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module hpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/hpq_cmp.sv =====
// Shared compare unit: strict cost less-than and coordinate match.
`timescale 1ns / 1ps

module hpq_cmp
  import hpq_pkg::*;
(
  input  entry_t a,
  input  entry_t b,
  output logic   lt,
  output logic   xy_eq
);

  assign lt    = a.cost < b.cost;
  assign xy_eq = (a.x == b.x) && (a.y == b.y);

endmodule

// ===== rtl/min_heap_priority_queue_top.sv =====
// Top level of the min-heap priority queue: sequencer, heap memory and compare unit.
`timescale 1ns / 1ps

// Binary min-heap priority queue keyed on an unsigned cost.
// The input channel (in_valid, in_stall, in_data) takes one operation per
// transfer: insert, extract minimum, find by coordinates, or clear. The
// result channel (out_valid, out_stall, out_data) returns exactly one result
// transfer per operation, in order, with a status, the returned entry, the
// entry count after the operation and an empty flag.
// Entries live in a RAM with registered read data, and each entry read in a
// walk or scan goes through the one shared comparator. Clear, full insert,
// empty extract and insert into an empty heap go straight to result load.
// Insert climbs while the new entry is strictly smaller than its parent.
// Extract reads the root, then, unless the heap is now empty, the last entry,
// which moves to the root and sinks while a child is strictly smaller.
// Find scans entries in array order, up to the count, until the first match.
// in_stall is high while an operation is in progress; one operation runs at
// a time. A finished result waits in the output register while the next
// operation is accepted; if the receiver stalls, the sequencer holds the
// following result until the output register frees up. Synchronous reset
// empties the heap (count to zero) and drops any pending result; the memory
// is not cleared since entries at or above the count are never read.

module min_heap_priority_queue_top
  import hpq_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int XW = AW + 2;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_EX_ROOT = 9'b000000010,
    S_EX_LAST = 9'b000000100,
    S_UP_CMP  = 9'b000001000,
    S_DN_RDR  = 9'b000010000,
    S_DN_CMP  = 9'b000100000,
    S_WR_ITEM = 9'b001000000,
    S_FD_SCAN = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic [AW-1:0]          pos_r, pos_nxt;
  entry_t                 item_r, item_nxt;
  entry_t                 best_r, best_nxt;
  logic [AW-1:0]          bidx_r, bidx_nxt;
  logic [STATUS_BITS-1:0] res_status_r, res_status_nxt;
  entry_t                 res_ent_r, res_ent_nxt;
  logic                   out_valid_r;
  out_t                   out_data_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  entry_t                 ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata_raw;
  entry_t                 rdata;

  entry_t                 cmp_a, cmp_b;
  logic                   cmp_lt, cmp_xy_eq;

  entry_t                 in_item;
  logic                   out_free;
  logic                   do_move;
  entry_t                 fin_best;
  logic [AW-1:0]          fin_idx;
  logic [XW-1:0]          left_idx, right_idx, next_left;
  logic [AW-1:0]          up_parent;

  assign rdata = entry_t'(ram_rdata_raw);

  hpq_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata_raw)
  );

  hpq_cmp u_cmp (
    .a    (cmp_a),
    .b    (cmp_b),
    .lt   (cmp_lt),
    .xy_eq(cmp_xy_eq)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign in_item.cost   = in_data.cost_key;
  assign in_item.x      = in_data.coord_x;
  assign in_item.y      = in_data.coord_y;
  assign in_item.handle = in_data.node_handle;

  // Child and parent positions of the current hole.
  assign left_idx  = (XW'(pos_r) << 1) + XW'(1);
  assign right_idx = (XW'(pos_r) << 1) + XW'(2);
  assign up_parent = AW'(pos_r - AW'(1)) >> 1;
  assign next_left = (XW'(fin_idx) << 1) + XW'(1);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    pos_nxt        = pos_r;
    item_nxt       = item_r;
    best_nxt       = best_r;
    bidx_nxt       = bidx_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    ram_we         = 1'b0;
    ram_waddr      = pos_r;
    ram_wdata      = item_r;
    ram_raddr      = '0;
    cmp_a          = rdata;
    cmp_b          = item_r;
    do_move        = 1'b0;
    fin_best       = best_r;
    fin_idx        = bidx_r;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = ST_OK;
          res_ent_nxt    = '0;
          item_nxt       = in_item;
          case (in_data.mode)
            MODE_INSERT: begin
              if (count_r == CW'(CAPACITY)) begin
                res_status_nxt = ST_FULL;
                state_nxt      = S_DONE;
              end else begin
                count_nxt = CW'(count_r + CW'(1));
                pos_nxt   = AW'(count_r);
                if (count_r == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = in_item;
                  state_nxt = S_DONE;
                end else begin
                  ram_raddr = AW'((count_r - CW'(1)) >> 1);
                  state_nxt = S_UP_CMP;
                end
              end
            end
            MODE_EXTRACT: begin
              if (count_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_DONE;
              end else begin
                count_nxt = CW'(count_r - CW'(1));
                ram_raddr = '0;
                state_nxt = S_EX_ROOT;
              end
            end
            MODE_FIND: begin
              res_status_nxt = ST_EMPTY;
              pos_nxt        = '0;
              ram_raddr      = '0;
              state_nxt      = (count_r == '0) ? S_DONE : S_FD_SCAN;
            end
            MODE_CLEAR: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
            default: begin
              count_nxt = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_EX_ROOT: begin
        res_ent_nxt = rdata;
        if (count_r == '0) begin
          state_nxt = S_DONE;
        end else begin
          ram_raddr = AW'(count_r);
          state_nxt = S_EX_LAST;
        end
      end
      S_EX_LAST: begin
        // The last entry becomes the item that sinks from the root.
        item_nxt = rdata;
        pos_nxt  = '0;
        if (count_r > CW'(1)) begin
          ram_raddr = AW'(1);
          state_nxt = S_DN_RDR;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          ram_wdata = rdata;
          state_nxt = S_DONE;
        end
      end
      S_DN_RDR: begin
        // Left child is in rdata; it wins only if strictly smaller.
        cmp_a    = rdata;
        cmp_b    = item_r;
        fin_best = cmp_lt ? rdata : item_r;
        fin_idx  = cmp_lt ? AW'(left_idx) : pos_r;
        best_nxt = fin_best;
        bidx_nxt = fin_idx;
        if (right_idx < XW'(count_r)) begin
          ram_raddr = AW'(right_idx);
          state_nxt = S_DN_CMP;
        end else begin
          do_move = 1'b1;
        end
      end
      S_DN_CMP: begin
        cmp_a    = rdata;
        cmp_b    = best_r;
        fin_best = cmp_lt ? rdata : best_r;
        fin_idx  = cmp_lt ? AW'(right_idx) : bidx_r;
        do_move  = 1'b1;
      end
      S_UP_CMP: begin
        // Parent is in rdata; the new entry climbs while strictly smaller.
        cmp_a = item_r;
        cmp_b = rdata;
        if (cmp_lt) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = rdata;
          pos_nxt   = up_parent;
          if (up_parent != '0) begin
            ram_raddr = AW'(up_parent - AW'(1)) >> 1;
          end else begin
            state_nxt = S_WR_ITEM;
          end
        end else begin
          ram_we    = 1'b1;
          ram_waddr = pos_r;
          ram_wdata = item_r;
          state_nxt = S_DONE;
        end
      end
      S_WR_ITEM: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = item_r;
        state_nxt = S_DONE;
      end
      S_FD_SCAN: begin
        cmp_a = rdata;
        cmp_b = item_r;
        if (cmp_xy_eq) begin
          res_status_nxt = ST_OK;
          res_ent_nxt    = rdata;
          state_nxt      = S_DONE;
        end else if (CW'(CW'(pos_r) + CW'(1)) < count_r) begin
          pos_nxt   = AW'(pos_r + AW'(1));
          ram_raddr = AW'(pos_r + AW'(1));
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // One sift-down level: either the item settles here, or the smaller
    // child moves up into the hole and the walk continues below it.
    if (do_move) begin
      ram_we    = 1'b1;
      ram_waddr = pos_r;
      if (fin_idx == pos_r) begin
        ram_wdata = item_r;
        state_nxt = S_DONE;
      end else begin
        ram_wdata = fin_best;
        pos_nxt   = fin_idx;
        if (next_left < XW'(count_r)) begin
          ram_raddr = AW'(next_left);
          state_nxt = S_DN_RDR;
        end else begin
          state_nxt = S_WR_ITEM;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    item_r       <= item_nxt;
    best_r       <= best_nxt;
    bidx_r       <= bidx_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    if (state_r == S_DONE && out_free) begin
      out_data_r.status      <= res_status_r;
      out_data_r.out_cost    <= res_ent_r.cost;
      out_data_r.out_x       <= res_ent_r.x;
      out_data_r.out_y       <= res_ent_r.y;
      out_data_r.out_handle  <= res_ent_r.handle;
      out_data_r.entry_count <= CNT_BITS'(count_r);
      out_data_r.is_empty    <= (count_r == '0);
    end
  end

  // The entry count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // A new result appears only from the result-load step.
  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the result-load step");

  // Climbing stops at the root, so the hole is never at the root here.
  a_up_not_root: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_UP_CMP |-> pos_r != '0)
    else $error("sift-up compare at the root");

  // Past the accept cycle, writes only land inside the live heap.
  a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r != S_IDLE) |-> (CW'(ram_waddr) < count_r))
    else $error("heap write beyond the entry count");

endmodule

// ===== dv/min_heap_priority_queue_top_test.sv =====
// Self-checking testbench for the min-heap priority queue top level.
`timescale 1ns / 1ps

module min_heap_priority_queue_top_test;
  import hpq_pkg::*;

  localparam int HEAP_DEPTH = 256;
  // After the last result, wait at least as long as a find over a full heap
  // takes, watching for any stray transfer on the result channel.
  localparam int SETTLE_CYCLES = 300;

  typedef struct {
    in_t item;
    bit  drain_first;  // hold this item back until no result is owed
  } pending_op_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t  in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  // Stimulus waiting to be offered on the input channel.
  pending_op_t pending_ops[$];
  int total_ops = 0;

  // Recent insert coordinates, so that finds hit stored entries often.
  logic [2*COORD_BITS-1:0] coord_pool[$];

  // Predicted copy of the heap and the results it still owes.
  entry_t      heap_mem[HEAP_DEPTH];
  int unsigned heap_count = 0;
  out_t        owed_results[$];
  out_t        head;

  // Counters written only by the monitor with nonblocking assignments, so
  // every other process reads a settled value.
  int ops_taken = 0;
  int owed_count = 0;
  int results_seen = 0;

  int error_count = 0;

  // No idling on either side while this stretch of inputs goes through.
  logic quiet_stretch;
  assign quiet_stretch = (ops_taken >= 300) && (ops_taken < 600);

  min_heap_priority_queue_top #(
    .CAPACITY(HEAP_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Idles with a chance of 12 in a hundred, outside the quiet stretch.
  function automatic bit idle_roll();
    return !quiet_stretch && ($urandom_range(0, 99) < 12);
  endfunction

  task automatic flag_error(string msg);
    $display("[%0t] ERROR result %0d: %s", $time, results_seen, msg);
    error_count++;
  endtask

  task automatic field_diff(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      flag_error($sformatf("%s is %0h, predicted %0h", name, got, want));
    end
  endtask

  // Applies one operation to the predicted heap and returns its result.
  // Sifting follows the usual array layout: parent (i-1)/2, children 2i+1 and
  // 2i+2. Comparisons are strict, so equal costs never swap, and when both
  // children tie below the parent the left one is taken.
  function automatic out_t heap_apply(in_t op);
    out_t        r;
    entry_t      moving;
    int unsigned pos;
    int unsigned parent;
    int unsigned kid;
    int unsigned best;
    bit          settled;
    r = '0;
    case (op.mode)
      MODE_INSERT: begin
        if (heap_count >= HEAP_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = heap_count;
          heap_mem[pos] = {op.cost_key, op.coord_x, op.coord_y, op.node_handle};
          heap_count++;
          settled = 1'b0;
          while (pos > 0 && !settled) begin
            parent = (pos - 1) / 2;
            if (heap_mem[pos].cost < heap_mem[parent].cost) begin
              moving = heap_mem[pos];
              heap_mem[pos] = heap_mem[parent];
              heap_mem[parent] = moving;
              pos = parent;
            end else begin
              settled = 1'b1;
            end
          end
        end
      end
      MODE_EXTRACT: begin
        if (heap_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_cost   = heap_mem[0].cost;
          r.out_x      = heap_mem[0].x;
          r.out_y      = heap_mem[0].y;
          r.out_handle = heap_mem[0].handle;
          heap_count--;
          if (heap_count > 0) begin
            heap_mem[0] = heap_mem[heap_count];
            pos = 0;
            settled = 1'b0;
            while (!settled) begin
              best = pos;
              kid = 2 * pos + 1;
              if (kid < heap_count && heap_mem[kid].cost < heap_mem[best].cost) begin
                best = kid;
              end
              if (kid + 1 < heap_count && heap_mem[kid + 1].cost < heap_mem[best].cost) begin
                best = kid + 1;
              end
              if (best == pos) begin
                settled = 1'b1;
              end else begin
                moving = heap_mem[pos];
                heap_mem[pos] = heap_mem[best];
                heap_mem[best] = moving;
                pos = best;
              end
            end
          end
        end
      end
      MODE_FIND: begin
        // First match in array order, not in cost order.
        r.status = ST_EMPTY;
        settled = 1'b0;
        for (int unsigned i = 0; i < heap_count; i++) begin
          if (!settled && heap_mem[i].x == op.coord_x && heap_mem[i].y == op.coord_y) begin
            r.status     = ST_OK;
            r.out_cost   = heap_mem[i].cost;
            r.out_x      = heap_mem[i].x;
            r.out_y      = heap_mem[i].y;
            r.out_handle = heap_mem[i].handle;
            settled = 1'b1;
          end
        end
      end
      default: begin
        // MODE_CLEAR: only the count goes; stored entries stay behind.
        heap_count = 0;
      end
    endcase
    r.entry_count = CNT_BITS'(heap_count);
    r.is_empty    = (heap_count == 0);
    return r;
  endfunction

  function automatic in_t make_item(logic [MODE_BITS-1:0] mode, logic [KEY_BITS-1:0] cost,
                                    logic [COORD_BITS-1:0] x, logic [COORD_BITS-1:0] y,
                                    logic [HANDLE_BITS-1:0] handle);
    return {mode, cost, x, y, handle};
  endfunction

  // Every field random; fields that the operation ignores still toggle.
  function automatic in_t random_item(logic [MODE_BITS-1:0] mode);
    in_t r;
    r.mode        = mode;
    r.cost_key    = KEY_BITS'($urandom);
    r.coord_x     = COORD_BITS'($urandom);
    r.coord_y     = COORD_BITS'($urandom);
    r.node_handle = HANDLE_BITS'($urandom);
    return r;
  endfunction

  // Costs lean toward the extremes and a tiny range, so ties are common.
  function automatic logic [KEY_BITS-1:0] pick_cost();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return KEY_BITS'($urandom_range(0, 7));
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // A small grid now and then gives duplicate coordinates in the heap.
  function automatic logic [COORD_BITS-1:0] pick_coord();
    if ($urandom_range(0, 9) < 3) begin
      return COORD_BITS'($urandom_range(0, 3));
    end
    return COORD_BITS'($urandom);
  endfunction

  task automatic queue_op(in_t item, bit drain_first);
    pending_op_t p;
    p.item = item;
    p.drain_first = drain_first;
    pending_ops.push_back(p);
    if (item.mode == MODE_INSERT) begin
      coord_pool.push_back({item.coord_x, item.coord_y});
      if (coord_pool.size() > 64) begin
        void'(coord_pool.pop_front());
      end
    end
  endtask

  // One random operation from a percentage mix; what is left over is clear.
  task automatic queue_random(int ins_pct, int ext_pct, int find_pct, bit drain_first);
    int   roll;
    in_t  item;
    logic [2*COORD_BITS-1:0] spot;
    roll = $urandom_range(0, 99);
    if (roll < ins_pct) begin
      item = random_item(MODE_INSERT);
      item.cost_key = pick_cost();
      item.coord_x  = pick_coord();
      item.coord_y  = pick_coord();
    end else if (roll < ins_pct + ext_pct) begin
      item = random_item(MODE_EXTRACT);
    end else if (roll < ins_pct + ext_pct + find_pct) begin
      item = random_item(MODE_FIND);
      if (coord_pool.size() != 0 && $urandom_range(0, 9) < 7) begin
        spot = coord_pool[$urandom_range(0, coord_pool.size() - 1)];
        item.coord_x = spot[2*COORD_BITS-1:COORD_BITS];
        item.coord_y = spot[COORD_BITS-1:0];
      end else if ($urandom_range(0, 1) == 0) begin
        item.coord_x = pick_coord();
        item.coord_y = pick_coord();
      end
    end else begin
      item = random_item(MODE_CLEAR);
    end
    queue_op(item, drain_first);
  endtask

  // Driver. A new item goes out only when the channel is free: nothing is
  // offered, or the offered item is transferred at this edge. A stalled item
  // stays on the bus unchanged. An item marked drain_first waits until the
  // previous one has been taken and every owed result has come back.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_ops.size() != 0 && !idle_roll() &&
          (!pending_ops[0].drain_first || (!in_valid && owed_count == 0))) begin
        in_valid <= 1'b1;
        in_data  <= pending_ops[0].item;
        void'(pending_ops.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor. Both channels are sampled at the same edge. A result can never
  // belong to an operation transferred at that very edge, so the result is
  // checked before the new prediction is queued. The receiver's stall is
  // drawn here as well.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      owed_count <= 0;
      ops_taken  <= 0;
      heap_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          flag_error($sformatf("result %h arrived with none outstanding", out_data));
        end else begin
          head = owed_results.pop_front();
          field_diff("status", out_data.status, head.status);
          field_diff("out_cost", out_data.out_cost, head.out_cost);
          field_diff("out_x", out_data.out_x, head.out_x);
          field_diff("out_y", out_data.out_y, head.out_y);
          field_diff("out_handle", out_data.out_handle, head.out_handle);
          field_diff("entry_count", out_data.entry_count, head.entry_count);
          field_diff("is_empty", out_data.is_empty, head.is_empty);
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid && !in_stall) begin
        owed_results.push_back(heap_apply(in_data));
        ops_taken <= ops_taken + 1;
      end
      owed_count <= owed_results.size();
      out_stall  <= idle_roll();
    end
  end

  initial begin
    // Directed opening: empty heap, field extremes, equal costs, duplicate
    // coordinates, draining to empty, and clear with stale entries behind.
    queue_op(make_item(MODE_EXTRACT, 24'h0, 12'h0, 12'h0, 16'h0), 1'b0);
    queue_op(make_item(MODE_FIND, 24'hFFFFFF, 12'h0, 12'h0, 16'hFFFF), 1'b0);
    queue_op(make_item(MODE_INSERT, 24'hFFFFFF, 12'hFFF, 12'hFFF, 16'hFFFF), 1'b0);
    queue_op(make_item(MODE_INSERT, 24'h000000, 12'h000, 12'h000, 16'h0000), 1'b0);
    queue_op(make_item(MODE_INSERT, 24'h800000, 12'h800, 12'h001, 16'h8000), 1'b0);
    queue_op(make_item(MODE_INSERT, 24'h800000, 12'h001, 12'h800, 16'h0001), 1'b0);
    queue_op(make_item(MODE_INSERT, 24'h800000, 12'hAAA, 12'h555, 16'h5A5A), 1'b0);
    queue_op(make_item(MODE_INSERT, 24'h000010, 12'h800, 12'h001, 16'h1234), 1'b0);
    queue_op(make_item(MODE_FIND, 24'h0, 12'hFFF, 12'hFFF, 16'h0), 1'b0);
    queue_op(make_item(MODE_FIND, 24'h0, 12'h800, 12'h001, 16'h0), 1'b0);
    queue_op(make_item(MODE_FIND, 24'h0, 12'h123, 12'h456, 16'h0), 1'b0);
    for (int n = 0; n < 7; n++) begin
      queue_op(random_item(MODE_EXTRACT), 1'b0);
    end
    queue_op(make_item(MODE_INSERT, 24'h555555, 12'h555, 12'hAAA, 16'hAAAA), 1'b0);
    queue_op(make_item(MODE_CLEAR, 24'hFFFFFF, 12'hFFF, 12'hFFF, 16'hFFFF), 1'b0);
    queue_op(make_item(MODE_FIND, 24'h0, 12'h555, 12'hAAA, 16'h0), 1'b0);
    queue_op(make_item(MODE_EXTRACT, 24'h0, 12'h0, 12'h0, 16'h0), 1'b0);
    queue_op(make_item(MODE_INSERT, 24'h7FFFFF, 12'h7FF, 12'h7FF, 16'h7FFF), 1'b0);
    queue_op(make_item(MODE_CLEAR, 24'h0, 12'h0, 12'h0, 16'h0), 1'b0);

    // Mixed traffic that keeps a moderate heap alive.
    for (int n = 0; n < 450; n++) begin
      queue_random(50, 30, 18, 1'b0);
    end

    // Fill past capacity so that inserts are dropped, after a pause in which
    // every outstanding result comes home.
    queue_op(random_item(MODE_CLEAR), 1'b1);
    for (int n = 0; n < 320; n++) begin
      queue_random(90, 0, 10, 1'b0);
    end

    // Drain the full heap and run a little past empty.
    queue_random(0, 100, 0, 1'b1);
    for (int n = 0; n < 300; n++) begin
      queue_random(4, 88, 8, 1'b0);
    end

    for (int n = 0; n < 56; n++) begin
      queue_random(45, 35, 17, 1'b0);
    end
    total_ops = pending_ops.size();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Checks are made away from the active edge, on settled counters.
    do begin
      @(negedge clk);
    end while (ops_taken != total_ops || owed_count != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);

    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // A correct run takes well under a tenth of this.
  initial begin
    #6000000;
    flag_error($sformatf("timeout with %0d of %0d operations taken and %0d results owed",
                         ops_taken, total_ops, owed_count));
    $display("Mismatches found");
    $finish;
  end

endmodule
